>>> rtl/pst_pkg.sv
package pst_pkg;

	// Run length limit and its counter width
	localparam int RUN_MAX = 8;
	localparam int RUN_W   = 3;

	// Width of the slot number carried in a result
	localparam int SLOT_OUT_W = 3;

	// Command codes
	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// Status codes
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic               func;
		logic [63:0]        key_first;
		logic [63:0]        key_second;
		logic [63:0]        user_word;
		logic signed [31:0] entry_priority;
	} pst_cmd_t;

	typedef struct packed {
		logic                  status;
		logic                  entry_valid;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic signed [31:0]    out_priority;
		logic [63:0]           out_key_first;
		logic [63:0]           out_key_second;
		logic [63:0]           out_user_word;
		logic                  last;
	} pst_res_t;

	// One entry of the word memory
	typedef struct packed {
		logic [63:0] key_first;
		logic [63:0] key_second;
		logic [63:0] user_word;
	} pst_words_t;

	// Memory port controls from the sequencer
	typedef struct packed {
		logic wr_en;
		logic prio_rd_en;
		logic word_rd_en;
	} pst_mem_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_SELECT,
		ST_FETCH,
		ST_EMIT
	} pst_state_t;

endpackage

>>> rtl/pst_store.sv
module pst_store import pst_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic                                   clk,
	input  pst_mem_ctl_t                           ctl,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
	input  logic signed [31:0]                     wr_prio,
	input  pst_words_t                             wr_words,
	output logic signed [31:0]                     rd_prio,
	output pst_words_t                             rd_words
);

	logic signed [31:0] prio_mem [SLOTS];
	pst_words_t         word_mem [SLOTS];

	// Write both memories together on an add
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			prio_mem[wr_addr] <= wr_prio;
			word_mem[wr_addr] <= wr_words;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.prio_rd_en) begin
			rd_prio <= prio_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.word_rd_en) begin
			rd_words <= word_mem[rd_addr];
		end
	end

endmodule

>>> rtl/pst_ctrl.sv
module pst_ctrl import pst_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [3:0]                             active,
	input  logic                                   cmd_valid,
	output logic                                   cmd_ready,
	input  pst_cmd_t                               cmd,
	input  logic                                   out_free,
	output logic                                   res_load,
	output pst_res_t                               res_next,
	output pst_mem_ctl_t                           ctl,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
	output logic signed [31:0]                     wr_prio,
	output pst_words_t                             wr_words,
	input  logic signed [31:0]                     rd_prio,
	input  pst_words_t                             rd_words
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int SX_W  = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;

	pst_state_t         state_q, state_d;
	logic [SLOTS-1:0]   used_q, used_d;
	logic [SLOTS-1:0]   emit_q, emit_d;
	logic [CNT_W-1:0]   idx_q, idx_d;
	logic               rd_vld_s1, rd_vld_d;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               best_found_q, best_found_d;
	logic signed [31:0] best_prio_q, best_prio_d;
	logic [IDX_W-1:0]   best_idx_q, best_idx_d;
	logic [CNT_W-1:0]   cand_cnt_q, cand_cnt_d;
	logic [RUN_W-1:0]   emit_cnt_q, emit_cnt_d;
	logic               last_q, last_d;
	logic               empty_q, empty_d;
	logic               status_q, status_d;
	logic [63:0]        key_first_q, key_second_q;

	logic [CNT_W-1:0]   n_live;
	logic               issue;
	logic               free_any;
	logic [IDX_W-1:0]   free_idx;
	logic [SX_W-1:0]    slot_ext;

	assign n_live = (int'(active) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(active);
	assign issue  = (idx_q < n_live);

	// Lowest empty live slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i] && (i < int'(n_live))) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign wr_addr  = free_idx;
	assign wr_prio  = cmd.entry_priority;
	assign wr_words = '{key_first: cmd.key_first, key_second: cmd.key_second,
		user_word: cmd.user_word};

	assign slot_ext = SX_W'(best_idx_q);

	always_comb begin
		res_next.status         = status_q;
		res_next.entry_valid    = !empty_q;
		res_next.slot_index     = empty_q ? '0 : slot_ext[SLOT_OUT_W-1:0];
		res_next.out_priority   = empty_q ? '0 : best_prio_q;
		res_next.out_key_first  = empty_q ? '0 : rd_words.key_first;
		res_next.out_key_second = empty_q ? '0 : rd_words.key_second;
		res_next.out_user_word  = empty_q ? '0 : rd_words.user_word;
		res_next.last           = last_q;
	end

	always_comb begin
		state_d      = state_q;
		used_d       = used_q;
		emit_d       = emit_q;
		idx_d        = idx_q;
		rd_vld_d     = 1'b0;
		best_found_d = best_found_q;
		best_prio_d  = best_prio_q;
		best_idx_d   = best_idx_q;
		cand_cnt_d   = cand_cnt_q;
		emit_cnt_d   = emit_cnt_q;
		last_d       = last_q;
		empty_d      = empty_q;
		status_d     = status_q;
		ctl          = '0;
		rd_addr      = idx_q[IDX_W-1:0];
		cmd_ready    = 1'b0;
		res_load     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					status_d   = STATUS_DONE;
					emit_d     = '0;
					emit_cnt_d = '0;
					idx_d      = '0;
					best_found_d = 1'b0;
					cand_cnt_d = '0;
					if (cmd.func == FUNC_ADD) begin
						if (free_any) begin
							ctl.wr_en        = 1'b1;
							used_d[free_idx] = 1'b1;
						end else begin
							status_d = STATUS_FULL;
						end
						state_d = ST_SELECT;
					end else begin
						state_d = ST_REMOVE;
					end
				end
			end

			ST_REMOVE: begin
				if (issue) begin
					ctl.word_rd_en = 1'b1;
					idx_d          = idx_q + 1'b1;
				end
				rd_vld_d = issue;
				if (rd_vld_s1 && used_q[rd_idx_s1] && (rd_words.key_first == key_first_q)
						&& (rd_words.key_second == key_second_q)) begin
					// First match: free it and drop the read still in flight
					used_d[rd_idx_s1] = 1'b0;
					idx_d    = '0;
					rd_vld_d = 1'b0;
					state_d  = ST_SELECT;
				end else if (!issue && !rd_vld_s1) begin
					idx_d   = '0;
					state_d = ST_SELECT;
				end
			end

			ST_SELECT: begin
				if (issue) begin
					ctl.prio_rd_en = 1'b1;
					idx_d          = idx_q + 1'b1;
				end
				rd_vld_d = issue;
				if (rd_vld_s1) begin
					if (used_q[rd_idx_s1] && !emit_q[rd_idx_s1]) begin
						cand_cnt_d = cand_cnt_q + 1'b1;
						if (!best_found_q || (rd_prio > best_prio_q)) begin
							best_found_d = 1'b1;
							best_prio_d  = rd_prio;
							best_idx_d   = rd_idx_s1;
						end
					end
				end else if (!issue) begin
					if (best_found_q) begin
						empty_d = 1'b0;
						last_d  = (cand_cnt_q == CNT_W'(1)) ||
							(emit_cnt_q == RUN_W'(RUN_MAX - 1));
						state_d = ST_FETCH;
					end else begin
						empty_d = 1'b1;
						last_d  = 1'b1;
						state_d = ST_EMIT;
					end
				end
			end

			ST_FETCH: begin
				ctl.word_rd_en = 1'b1;
				rd_addr        = best_idx_q;
				state_d        = ST_EMIT;
			end

			ST_EMIT: begin
				if (out_free) begin
					res_load = 1'b1;
					if (last_q) begin
						state_d = ST_IDLE;
					end else begin
						emit_d[best_idx_q] = 1'b1;
						emit_cnt_d   = emit_cnt_q + 1'b1;
						idx_d        = '0;
						best_found_d = 1'b0;
						cand_cnt_d   = '0;
						state_d      = ST_SELECT;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			emit_q       <= '0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			best_found_q <= 1'b0;
			cand_cnt_q   <= '0;
			emit_cnt_q   <= '0;
			last_q       <= 1'b0;
			empty_q      <= 1'b0;
			status_q     <= STATUS_DONE;
		end else begin
			state_q      <= state_d;
			used_q       <= used_d;
			emit_q       <= emit_d;
			idx_q        <= idx_d;
			rd_vld_s1    <= rd_vld_d;
			best_found_q <= best_found_d;
			cand_cnt_q   <= cand_cnt_d;
			emit_cnt_q   <= emit_cnt_d;
			last_q       <= last_d;
			empty_q      <= empty_d;
			status_q     <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1   <= idx_q[IDX_W-1:0];
		best_prio_q <= best_prio_d;
		best_idx_q  <= best_idx_d;
		if (cmd_valid && cmd_ready) begin
			key_first_q  <= cmd.key_first;
			key_second_q <= cmd.key_second;
		end
	end

endmodule

>>> rtl/priority_slot_table_top.sv
// Rate: one command at a time. An add writes its entry and a remove first searches
// the word memory for the matching keys; then the table lists entries by rank,
// with one full priority memory pass per rank and up to RUN_MAX results per run.
// Reset: asynchronous, active low; all slots empty, active slot count 8, no
// item pending. Entry memories are not cleared; empty slots are never listed in a result.
module priority_slot_table_top import pst_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  pst_cmd_t   cmd,
	output logic       res_valid,
	input  logic       res_ready,
	output pst_res_t   res
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic               [3:0] active_q;
	pst_mem_ctl_t       mem_ctl;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic signed [31:0] wr_prio;
	logic signed [31:0] rd_prio;
	pst_words_t         wr_words;
	pst_words_t         rd_words;
	logic               out_free;
	logic               res_load;
	pst_res_t           res_next;
	logic               res_valid_q;
	pst_res_t           res_q;

	// Active slot count register. The user must write it only while the block is idle;
	// the block itself does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 4'd8;
		end else if (cfg_valid) begin
			active_q <= cfg_data;
		end
	end

	// Sequencer: holds the used bits, runs the remove search and the
	// per-rank selection passes over the priority memory.
	pst_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.active   (active_q),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.out_free (out_free),
		.res_load (res_load),
		.res_next (res_next),
		.ctl      (mem_ctl),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.wr_prio  (wr_prio),
		.wr_words (wr_words),
		.rd_prio  (rd_prio),
		.rd_words (rd_words)
	);

	// Entry storage: a priority memory scanned on every pass and a word
	// memory read for key matching and for the listed entry.
	pst_store #(
		.SLOTS(SLOTS)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.wr_prio (wr_prio),
		.wr_words(wr_words),
		.rd_prio (rd_prio),
		.rd_words(rd_words)
	);

	// Output register: hold a result until taken; load a new one in the same
	// cycle as the old one leaves. The last item of a run may wait here while
	// the next command is accepted.
	assign out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> rtl/pst_checker.sv
module pst_checker import pst_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     cmd_valid,
	input logic     cmd_ready,
	input logic     res_valid,
	input logic     res_ready,
	input pst_res_t res
);

	// A stalled item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	// Busy after taking a command
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous one still in work");

	// An empty listing is a single item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.entry_valid |-> res.last)
		else $error("empty listing item without last");

	// An empty listing carries no entry contents
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.entry_valid |-> (res.slot_index == '0) &&
		(res.out_priority == '0) && (res.out_key_first == '0) &&
		(res.out_key_second == '0) && (res.out_user_word == '0))
		else $error("empty listing item with non-zero contents");

endmodule

bind priority_slot_table_top pst_checker u_pst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res      (res)
);
